@@ src/wcp_pkg.sv @@
// Shared types, constants and tag tables for the WAV chunk header parser.
`timescale 1ns / 1ps
`default_nettype none

package wcp_pkg;

    // Parser phases
    typedef enum logic [2:0] {
        PH_RIFF = 3'd0,
        PH_HEAD = 3'd1,
        PH_FMT  = 3'd2,
        PH_SKIP = 3'd3,
        PH_DONE = 3'd4,
        PH_FAIL = 3'd5
    } t_phase;

    // Kind of chunk whose header is being read
    typedef enum logic [1:0] {
        TAG_OTHER = 2'd0,
        TAG_FMT   = 2'd1,
        TAG_DATA  = 2'd2
    } t_tag;

    // Lengths, counted in bytes
    localparam logic [4:0] RIFF_LEN = 5'd12;
    localparam logic [4:0] HEAD_LEN = 5'd8;
    localparam logic [4:0] FMT_MIN  = 5'd16;

    // Highest byte address just past the end of a following chunk header
    localparam logic [33:0] POS_LIMIT = 34'h0_FFFF_FFFF;

    // One verdict item
    typedef struct packed {
        logic        ok;
        logic [31:0] sample_rate;
        logic [15:0] channel_count;
        logic [15:0] sample_bits;
        logic [31:0] pcm_offset;
        logic [31:0] pcm_size;
    } t_result;

    // Expected byte of the RIFF header; the size bytes are never compared
    function automatic logic [7:0] riff_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h52; // R
            4'd1:    c = 8'h49; // I
            4'd2:    c = 8'h46; // F
            4'd3:    c = 8'h46; // F
            4'd8:    c = 8'h57; // W
            4'd9:    c = 8'h41; // A
            4'd10:   c = 8'h56; // V
            4'd11:   c = 8'h45; // E
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "fmt " chunk tag
    function automatic logic [7:0] fmt_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h66; // f
            2'd1:    c = 8'h6D; // m
            2'd2:    c = 8'h74; // t
            default: c = 8'h20; // space
        endcase
        return c;
    endfunction

    // "data" chunk tag
    function automatic logic [7:0] data_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h64; // d
            2'd1:    c = 8'h61; // a
            2'd2:    c = 8'h74; // t
            default: c = 8'h61; // a
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ src/wav_chunk_header_parser.sv @@
// Top level of the WAV chunk header parser.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+----------------------------------
//   in      | input     | i_in_valid / o_in_ready   | i_data_byte, i_final_byte
//   out     | output    | o_out_valid / i_out_ready | o_ok, o_sample_rate, o_channel_count,
//           |           |                           | o_sample_bits, o_pcm_offset, o_pcm_size
//
// One byte item per cycle is accepted while no final byte is held back; each is parsed as it
// leaves the input register, and a final byte's verdict is loaded into the result register at
// that same edge, so o_out_valid comes from the result register, behind the input register.
// The per-byte update (one 34-bit add and compare for the skip range) sets the cycle.
// Synchronous active-low reset clears both stages and the parser state.
// A final byte holds in the input register while the result register is full and
// not taken; other bytes flow regardless of the output side.
`timescale 1ns / 1ps
`default_nettype none

module wav_chunk_header_parser
    import wcp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_final_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_ok,
    output logic [31:0]      o_sample_rate,
    output logic [15:0]      o_channel_count,
    output logic [15:0]      o_sample_bits,
    output logic [31:0]      o_pcm_offset,
    output logic [31:0]      o_pcm_size
);

    logic       out_free;
    logic       step;
    logic [7:0] step_byte;
    logic       step_final;
    t_result    verdict;
    t_result    held;

    // Input register
    wcp_in_stage u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .i_out_free   (out_free),
        .o_ready      (o_in_ready),
        .o_step       (step),
        .o_byte       (step_byte),
        .o_final      (step_final)
    );

    // Chunk walk
    wcp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (step_byte),
        .i_final  (step_final),
        .o_result (verdict)
    );

    // Result register
    wcp_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step && step_final),
        .i_result (verdict),
        .i_ready  (i_out_ready),
        .o_valid  (o_out_valid),
        .o_result (held),
        .o_free   (out_free)
    );

    assign o_ok            = held.ok;
    assign o_sample_rate   = held.sample_rate;
    assign o_channel_count = held.channel_count;
    assign o_sample_bits   = held.sample_bits;
    assign o_pcm_offset    = held.pcm_offset;
    assign o_pcm_size      = held.pcm_size;

endmodule

`default_nettype wire

@@ src/wcp_in_stage.sv @@
// Input register stage: holds one byte item until the parser can consume it.
`timescale 1ns / 1ps
`default_nettype none

module wcp_in_stage
    import wcp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_final_byte,
    input  wire logic       i_out_free,
    output logic            o_ready,
    output logic            o_step,
    output logic [7:0]      o_byte,
    output logic            o_final
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_final;

    // A final byte waits until the result register has room
    assign o_step  = r_valid && (!r_final || i_out_free);
    assign o_ready = !r_valid || o_step;
    assign o_byte  = r_byte;
    assign o_final = r_final;

    // Occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte  <= i_data_byte;
            r_final <= i_final_byte;
        end
    end

endmodule

`default_nettype wire

@@ src/wcp_parser.sv @@
// Parser state and per-byte update of the RIFF/WAVE chunk walk.
`timescale 1ns / 1ps
`default_nettype none

module wcp_parser
    import wcp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_final,
    output t_result         o_result
);

    t_phase      r_phase,    n_phase;
    logic [31:0] r_pos,      n_pos;
    logic [4:0]  r_idx,      n_idx;
    logic        r_match,    n_match;
    t_tag        r_tag,      n_tag;
    logic [31:0] r_len,      n_len;
    logic [32:0] r_skip,     n_skip;
    logic [31:0] r_rate,     n_rate;
    logic [15:0] r_chans,    n_chans;
    logic [15:0] r_bits,     n_bits;
    logic [31:0] r_offset,   n_offset;
    logic [31:0] r_size,     n_size;
    logic        r_fmt_seen, n_fmt_seen;
    logic        r_dat_seen, n_dat_seen;

    logic [4:0]  idx_inc;
    logic [31:0] len_fin;
    logic        pad;
    logic [33:0] next_end;
    logic        fits;
    logic        go_head;

    // Header length as it stands once the last size byte is in
    assign idx_inc  = r_idx + 5'd1;
    assign len_fin  = {i_byte, r_len[23:0]};
    assign pad      = len_fin[0];
    // Next header start plus its eight bytes must stay inside 32 bits
    assign next_end = {2'b00, r_pos} + {2'b00, len_fin} + {33'd0, pad} + 34'd9;
    assign fits     = (next_end <= POS_LIMIT);

    // Next state
    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_idx      = r_idx;
        n_match    = r_match;
        n_tag      = r_tag;
        n_len      = r_len;
        n_skip     = r_skip;
        n_rate     = r_rate;
        n_chans    = r_chans;
        n_bits     = r_bits;
        n_offset   = r_offset;
        n_size     = r_size;
        n_fmt_seen = r_fmt_seen;
        n_dat_seen = r_dat_seen;
        go_head    = 1'b0;
        if (i_step) begin
            case (r_phase)
                PH_RIFF: begin
                    if ((r_idx < 5'd4 || r_idx >= 5'd8) && i_byte != riff_char(r_idx[3:0])) begin
                        n_match = 1'b0;
                    end
                    n_idx = idx_inc;
                    if (idx_inc >= RIFF_LEN) begin
                        if (n_match) begin
                            go_head = 1'b1;
                        end else begin
                            n_phase = PH_FAIL;
                        end
                    end
                end
                PH_HEAD: begin
                    if (r_idx == 5'd0) begin
                        if (i_byte == fmt_char(2'd0)) begin
                            n_tag = TAG_FMT;
                        end else if (i_byte == data_char(2'd0)) begin
                            n_tag = TAG_DATA;
                        end else begin
                            n_tag = TAG_OTHER;
                        end
                    end else if (r_idx < 5'd4) begin
                        if ((r_tag == TAG_FMT && i_byte != fmt_char(r_idx[1:0])) ||
                            (r_tag == TAG_DATA && i_byte != data_char(r_idx[1:0]))) begin
                            n_tag = TAG_OTHER;
                        end
                    end else begin
                        // size is little endian; lanes start cleared
                        n_len[8*r_idx[1:0] +: 8] = i_byte;
                    end
                    n_idx = idx_inc;
                    // Header complete: decide what follows
                    if (idx_inc >= HEAD_LEN) begin
                        if (r_tag == TAG_FMT) begin
                            if (len_fin < {27'd0, FMT_MIN} || !fits) begin
                                n_phase = PH_FAIL;
                            end else begin
                                n_skip  = {1'b0, len_fin} - {28'd0, FMT_MIN} + {32'd0, pad};
                                n_phase = PH_FMT;
                                n_idx   = 5'd0;
                            end
                        end else if (r_tag == TAG_DATA && r_fmt_seen) begin
                            n_offset   = r_pos + 32'd1;
                            n_size     = len_fin;
                            n_dat_seen = 1'b1;
                            n_phase    = PH_DONE;
                        end else begin
                            if (r_tag == TAG_DATA) begin
                                n_offset   = r_pos + 32'd1;
                                n_size     = len_fin;
                                n_dat_seen = 1'b1;
                            end
                            if (!fits) begin
                                n_phase = PH_FAIL;
                            end else begin
                                n_skip = {1'b0, len_fin} + {32'd0, pad};
                                if (n_skip == 33'd0) begin
                                    go_head = 1'b1;
                                end else begin
                                    n_phase = PH_SKIP;
                                end
                            end
                        end
                    end
                end
                PH_FMT: begin
                    case (r_idx) inside
                        [5'd2:5'd3]:   n_chans[8*r_idx[0] +: 8] = i_byte;
                        [5'd4:5'd7]:   n_rate[8*r_idx[1:0] +: 8] = i_byte;
                        [5'd14:5'd15]: n_bits[8*r_idx[0] +: 8] = i_byte;
                        default:       ;
                    endcase
                    n_idx = idx_inc;
                    if (idx_inc >= FMT_MIN) begin
                        n_fmt_seen = 1'b1;
                        if (r_dat_seen) begin
                            n_phase = PH_DONE;
                        end else if (r_skip == 33'd0) begin
                            go_head = 1'b1;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    if (r_skip != 33'd0) begin
                        n_skip = r_skip - 33'd1;
                    end
                    if (n_skip == 33'd0) begin
                        go_head = 1'b1;
                    end
                end
                default: ;
            endcase
            // Start of a new chunk header
            if (go_head) begin
                n_phase = PH_HEAD;
                n_idx   = 5'd0;
                n_tag   = TAG_OTHER;
                n_len   = 32'd0;
            end
            n_pos = r_pos + 32'd1;
        end
    end

    // Verdict, taken from the state after this byte
    always_comb begin
        o_result.ok            = (n_phase == PH_DONE);
        o_result.sample_rate   = o_result.ok ? n_rate   : 32'd0;
        o_result.channel_count = o_result.ok ? n_chans  : 16'd0;
        o_result.sample_bits   = o_result.ok ? n_bits   : 16'd0;
        o_result.pcm_offset    = o_result.ok ? n_offset : 32'd0;
        o_result.pcm_size      = o_result.ok ? n_size   : 32'd0;
    end

    // State registers; the final byte returns everything to reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_final)) begin
            r_phase    <= PH_RIFF;
            r_pos      <= 32'd0;
            r_idx      <= 5'd0;
            r_match    <= 1'b1;
            r_tag      <= TAG_OTHER;
            r_len      <= 32'd0;
            r_skip     <= 33'd0;
            r_rate     <= 32'd0;
            r_chans    <= 16'd0;
            r_bits     <= 16'd0;
            r_offset   <= 32'd0;
            r_size     <= 32'd0;
            r_fmt_seen <= 1'b0;
            r_dat_seen <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_idx      <= n_idx;
            r_match    <= n_match;
            r_tag      <= n_tag;
            r_len      <= n_len;
            r_skip     <= n_skip;
            r_rate     <= n_rate;
            r_chans    <= n_chans;
            r_bits     <= n_bits;
            r_offset   <= n_offset;
            r_size     <= n_size;
            r_fmt_seen <= n_fmt_seen;
            r_dat_seen <= n_dat_seen;
        end
    end

`ifndef SYNTHESIS
    // Done only once both chunks have been seen
    a_done_needs_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE) |-> (r_fmt_seen && r_dat_seen))
        else $error("done reached without fmt and data chunks");

    // Final byte leaves the parser in its reset state
    a_final_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_final) |=> (r_phase == PH_RIFF && r_pos == 32'd0 && !r_fmt_seen))
        else $error("parser not reset after final byte");

    // Header byte counter stays inside the RIFF header
    a_riff_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_RIFF) |-> (r_idx < RIFF_LEN))
        else $error("RIFF byte index out of range");

    // A skip in progress always has bytes left
    a_skip_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SKIP) |-> (r_skip != 33'd0))
        else $error("skip phase with nothing left to skip");
`endif

endmodule

`default_nettype wire

@@ src/wcp_out_stage.sv @@
// Result register: holds one verdict item until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module wcp_out_stage
    import wcp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  t_result      i_result,
    input  wire logic    i_ready,
    output logic         o_valid,
    output t_result      o_result,
    output logic         o_free
);

    logic    r_valid;
    t_result r_result;

    assign o_valid  = r_valid;
    assign o_result = r_result;
    assign o_free   = !r_valid || i_ready;

    // Occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire
